### sv/cpst_pkg.sv
// Shared types and constants for the convex polygon span table.
`default_nettype none
package cpst_pkg;

   localparam int QDEPTH = 4;
   localparam int QPW    = $clog2(QDEPTH);

   localparam logic signed [15:0] LEFT_EMPTY  = 16'sh7FFF;
   localparam logic signed [15:0] RIGHT_EMPTY = 16'sh8000;

   typedef struct packed {
      logic               is_read;
      logic signed [15:0] x_top;
      logic signed [15:0] y_top;
      logic signed [15:0] x_bot;
      logic signed [15:0] y_bot;
      logic [8:0]         row;
      logic               ok;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic room2;
   } qstat_type;

endpackage
`default_nettype wire

### sv/cpst_ram.sv
// Generic single write port, registered read port RAM.
`default_nettype none
module cpst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

### sv/cpst_queue.sv
// Command queue between the vertex front end and the row walker.
`default_nettype none
module cpst_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire cpst_pkg::cmd_type  push_cmd,
   input  wire logic               pop,
   output cpst_pkg::cmd_type       head,
   output cpst_pkg::qstat_type     stat
);
   import cpst_pkg::*;

   cmd_type        mem_ff [QDEPTH];
   logic [QPW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QPW:0]   cnt_ff, cnt_in;

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (QPW+1)'(push) - (QPW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= push_cmd;
      end
   end

   assign head       = mem_ff[rp_ff];
   assign stat.empty = (cnt_ff == '0);
   assign stat.room2 = (cnt_ff <= (QPW+1)'(QDEPTH-2));
endmodule
`default_nettype wire

### sv/cpst_front.sv
// Front end: accepts beats, tracks polygon vertices, queues edge and read commands.
`default_nettype none
module cpst_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                hold,
   input  wire logic                mode,
   input  wire logic signed [15:0]  vert_x,
   input  wire logic signed [15:0]  vert_y,
   input  wire logic                close_poly,
   input  wire logic [8:0]          read_row,
   input  wire cpst_pkg::qstat_type qstat,
   output logic                     busy,
   output logic                     push,
   output cpst_pkg::cmd_type        push_cmd
);
   import cpst_pkg::*;

   logic signed [15:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [15:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic               ok_ff, ok_in;
   logic               pend_ff, pend_in;
   cmd_type            pcmd_ff, pcmd_in;

   logic               accept, e1_v, e2_v;
   logic signed [15:0] fx, fy;
   cmd_type            e1, e2, rcmd;

   function automatic cmd_type mk_edge(logic signed [15:0] xa, logic signed [15:0] ya,
                                       logic signed [15:0] xb, logic signed [15:0] yb);
      cmd_type c;
      c         = '0;
      c.is_read = 1'b0;
      if (ya < yb) begin
         c.x_top = xa; c.y_top = ya; c.x_bot = xb; c.y_bot = yb;
      end else begin
         c.x_top = xb; c.y_top = yb; c.x_bot = xa; c.y_bot = ya;
      end
      return c;
   endfunction

   always_comb begin
      busy   = hold | pend_ff | ~qstat.room2;
      accept = start & ~busy;
      fx     = (cnt_ff == 2'd0) ? vert_x : first_x_ff;
      fy     = (cnt_ff == 2'd0) ? vert_y : first_y_ff;
      e1_v   = (cnt_ff != 2'd0) && (prev_y_ff != vert_y);
      e2_v   = close_poly && (vert_y != fy);
      e1     = mk_edge(prev_x_ff, prev_y_ff, vert_x, vert_y);
      e2     = mk_edge(vert_x, vert_y, fx, fy);
      rcmd         = '0;
      rcmd.is_read = 1'b1;
      rcmd.row     = read_row;
      rcmd.ok      = ok_ff;

      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      cnt_in     = cnt_ff;
      ok_in      = ok_ff;
      pend_in    = 1'b0;
      pcmd_in    = pcmd_ff;
      push       = 1'b0;
      push_cmd   = rcmd;

      if (pend_ff) begin
         push     = 1'b1;
         push_cmd = pcmd_ff;
      end else if (accept) begin
         if (mode) begin
            push     = 1'b1;
            push_cmd = rcmd;
         end else begin
            first_x_in = fx;
            first_y_in = fy;
            prev_x_in  = vert_x;
            prev_y_in  = vert_y;
            cnt_in     = (cnt_ff == 2'd3) ? cnt_ff : cnt_ff + 2'd1;
            if (close_poly) begin
               ok_in  = (cnt_in == 2'd3);
               cnt_in = 2'd0;
            end
            if (e1_v) begin
               push     = 1'b1;
               push_cmd = e1;
               pend_in  = e2_v;
               pcmd_in  = e2;
            end else if (e2_v) begin
               push     = 1'b1;
               push_cmd = e2;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_x_ff <= '0;
         first_y_ff <= '0;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
         cnt_ff     <= '0;
         ok_ff      <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         first_x_ff <= first_x_in;
         first_y_ff <= first_y_in;
         prev_x_ff  <= prev_x_in;
         prev_y_ff  <= prev_y_in;
         cnt_ff     <= cnt_in;
         ok_ff      <= ok_in;
         pend_ff    <= pend_in;
      end
      pcmd_ff <= pcmd_in;
   end
endmodule
`default_nettype wire

### sv/cpst_back.sv
// Back end: clearing pass, slope division, start offset, row walk and span reads over the row RAM.
`default_nettype none
module cpst_back #(
   parameter int ROWS = 512
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cpst_pkg::qstat_type qstat,
   input  wire cpst_pkg::cmd_type  head,
   output logic                    pop,
   output logic                    clearing,
   output logic                    rsp_valid,
   output logic                    rsp_span_valid,
   output logic signed [15:0]      rsp_span_left,
   output logic signed [15:0]      rsp_span_right
);
   import cpst_pkg::*;

   localparam int AW = $clog2(ROWS);
   localparam int YW = $clog2(ROWS + 1);
   localparam logic signed [16:0] ROWS_S = 17'(ROWS);
   localparam logic [12:0]        ROWS_U = 13'(ROWS);

   typedef enum logic [7:0] {
      S_CLR  = 8'b0000_0001,
      S_IDLE = 8'b0000_0010,
      S_RDW  = 8'b0000_0100,
      S_DIV  = 8'b0000_1000,
      S_MUL  = 8'b0001_0000,
      S_WRD  = 8'b0010_0000,
      S_WWR  = 8'b0100_0000,
      S_SPR  = 8'b1000_0000
   } st_type;

   st_type             st_ff, st_in;
   logic [YW-1:0]      y_ff, y_in, yend_ff, yend_in;
   cmd_type            cur_ff, cur_in;
   logic [31:0]        dq_ff, dq_in;
   logic [15:0]        rem_ff, rem_in, dy_ff, dy_in, off_ff, off_in;
   logic               neg_ff, neg_in;
   logic [4:0]         step_ff, step_in;
   logic signed [34:0] mc_ff, mc_in, acc_ff, acc_in, slope_ff, slope_in;
   logic               rv_ff, rv_in, sv_ff, sv_in;
   logic signed [15:0] sl_ff, sl_in, sr_ff, sr_in;

   logic               we;
   logic [AW-1:0]      waddr, raddr;
   logic [31:0]        wdata, rdata;

   logic signed [16:0] ys, ye, dx, dmag, dyw, offw;
   logic [16:0]        rem_sh, rem_sub;
   logic               ge;
   logic [31:0]        dq_n;
   logic signed [34:0] q35;
   logic signed [18:0] xi19;
   logic signed [15:0] xi, l, r, nl, nr;

   cpst_ram #(.WIDTH(32), .DEPTH(ROWS)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      ys   = (head.y_top < 16'sd0) ? 17'sd0 : 17'(head.y_top);
      ye   = (17'(head.y_bot) > ROWS_S) ? ROWS_S : 17'(head.y_bot);
      dx   = 17'(head.x_bot) - 17'(head.x_top);
      dmag = dx[16] ? -dx : dx;
      dyw  = 17'(head.y_bot) - 17'(head.y_top);
      offw = ys - 17'(head.y_top);

      rem_sh  = {rem_ff, dq_ff[31]};
      rem_sub = rem_sh - {1'b0, dy_ff};
      ge      = (rem_sh >= {1'b0, dy_ff});
      dq_n    = {dq_ff[30:0], ge};
      q35     = {3'b000, dq_n};

      xi19 = acc_ff[34:16] + 19'(acc_ff[34] & (|acc_ff[15:0]));
      xi   = xi19[15:0];
      l    = rdata[31:16];
      r    = rdata[15:0];
      nl   = (xi < l) ? xi : l;
      nr   = (xi > r) ? xi : r;

      st_in    = st_ff;
      y_in     = y_ff;
      yend_in  = yend_ff;
      cur_in   = cur_ff;
      dq_in    = dq_ff;
      rem_in   = rem_ff;
      dy_in    = dy_ff;
      off_in   = off_ff;
      neg_in   = neg_ff;
      step_in  = step_ff;
      mc_in    = mc_ff;
      acc_in   = acc_ff;
      slope_in = slope_ff;
      rv_in    = 1'b0;
      sv_in    = sv_ff;
      sl_in    = sl_ff;
      sr_in    = sr_ff;
      pop      = 1'b0;
      we       = 1'b0;
      waddr    = y_ff[AW-1:0];
      wdata    = {LEFT_EMPTY, RIGHT_EMPTY};
      raddr    = y_ff[AW-1:0];

      unique case (st_ff)
         S_CLR: begin
            we   = 1'b1;
            y_in = y_ff + 1'b1;
            if (y_ff == YW'(ROWS - 1)) begin
               st_in = S_IDLE;
            end
         end
         S_IDLE: begin
            raddr = AW'(head.row);
            if (!qstat.empty) begin
               pop    = 1'b1;
               cur_in = head;
               if (head.is_read) begin
                  if ({4'b0000, head.row} < ROWS_U) begin
                     st_in = S_RDW;
                  end else begin
                     rv_in = 1'b1;
                     sv_in = 1'b0;
                     sl_in = '0;
                     sr_in = '0;
                  end
               end else if (ys < ye) begin
                  y_in    = ys[YW-1:0];
                  yend_in = ye[YW-1:0];
                  neg_in  = dx[16];
                  dq_in   = {dmag[15:0], 16'h0000};
                  rem_in  = '0;
                  dy_in   = dyw[15:0];
                  off_in  = offw[15:0];
                  step_in = '0;
                  st_in   = S_DIV;
               end
            end
         end
         S_RDW: begin
            we    = 1'b1;
            waddr = AW'(cur_ff.row);
            rv_in = 1'b1;
            if (cur_ff.ok && (l <= r)) begin
               sv_in = 1'b1;
               sl_in = l;
               sr_in = r;
            end else begin
               sv_in = 1'b0;
               sl_in = '0;
               sr_in = '0;
            end
            st_in = S_IDLE;
         end
         S_DIV: begin
            dq_in   = dq_n;
            rem_in  = ge ? rem_sub[15:0] : rem_sh[15:0];
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               slope_in = neg_ff ? -q35 : q35;
               mc_in    = neg_ff ? -q35 : q35;
               acc_in   = {{3{cur_ff.x_top[15]}}, cur_ff.x_top, 16'h0000};
               st_in    = S_MUL;
            end
         end
         S_MUL: begin
            if (off_ff == '0) begin
               st_in = S_WRD;
            end else begin
               if (off_ff[0]) begin
                  acc_in = acc_ff + mc_ff;
               end
               mc_in  = mc_ff <<< 1;
               off_in = off_ff >> 1;
            end
         end
         S_WRD: begin
            st_in = S_WWR;
         end
         S_WWR: begin
            we     = 1'b1;
            wdata  = {nl, nr};
            acc_in = acc_ff + slope_ff;
            y_in   = y_ff + 1'b1;
            st_in  = (y_in == yend_ff) ? S_IDLE : S_WRD;
         end
         S_SPR: begin
            st_in = S_IDLE;
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLR;
         y_ff  <= '0;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         y_ff  <= y_in;
         rv_ff <= rv_in;
      end
      yend_ff  <= yend_in;
      cur_ff   <= cur_in;
      dq_ff    <= dq_in;
      rem_ff   <= rem_in;
      dy_ff    <= dy_in;
      off_ff   <= off_in;
      neg_ff   <= neg_in;
      step_ff  <= step_in;
      mc_ff    <= mc_in;
      acc_ff   <= acc_in;
      slope_ff <= slope_in;
      sv_ff    <= sv_in;
      sl_ff    <= sl_in;
      sr_ff    <= sr_in;
   end

   assign clearing       = (st_ff == S_CLR);
   assign rsp_valid      = rv_ff;
   assign rsp_span_valid = sv_ff;
   assign rsp_span_left  = sl_ff;
   assign rsp_span_right = sr_ff;
endmodule
`default_nettype wire

### sv/convex_polygon_span_table.sv
// Top level of the convex polygon span table.
// Vertex beats are taken by a front end into a 4-deep command queue; a back end
// works each edge: it takes the edge, runs a bit-serial slope division, steps
// the start offset by shift-and-add when the edge begins above row 0, then
// reads and writes back each table row in turn through the single row RAM. A
// read beat reads its row and clears it; a row beyond the table is answered
// straight from the idle state with no span. After reset a clearing pass over
// all ROWS rows runs with busy high. Each read gives one result on rsp_valid
// for one cycle; the receiver cannot stall it. Vertex beats give none.
`default_nettype none
module convex_polygon_span_table #(
   parameter int ROWS = 512
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_mode,
   input  wire logic signed [15:0] req_vert_x,
   input  wire logic signed [15:0] req_vert_y,
   input  wire logic               req_close_poly,
   input  wire logic [8:0]         req_read_row,
   output logic                    rsp_valid,
   output logic                    rsp_span_valid,
   output logic signed [15:0]      rsp_span_left,
   output logic signed [15:0]      rsp_span_right
);
   import cpst_pkg::*;

   qstat_type qstat;
   cmd_type   push_cmd, head;
   logic      push, pop, clearing;

   cpst_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .hold       (clearing),
      .mode       (req_mode),
      .vert_x     (req_vert_x),
      .vert_y     (req_vert_y),
      .close_poly (req_close_poly),
      .read_row   (req_read_row),
      .qstat      (qstat),
      .busy       (busy),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   cpst_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .stat     (qstat)
   );

   cpst_back #(.ROWS(ROWS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .qstat          (qstat),
      .head           (head),
      .pop            (pop),
      .clearing       (clearing),
      .rsp_valid      (rsp_valid),
      .rsp_span_valid (rsp_span_valid),
      .rsp_span_left  (rsp_span_left),
      .rsp_span_right (rsp_span_right)
   );
endmodule
`default_nettype wire
